FILE: sv/ftpa_pkg.sv
// Shared types, constants and register indexes for the first-touch page allocator.
`timescale 1ns / 1ps
`default_nettype none
package ftpa_pkg;

    localparam int VA_W       = 64;
    localparam int VPN_W      = 58;
    localparam int OFF_W      = 30;
    localparam int SHIFT_W    = 5;
    localparam int SHARE_W    = 17;
    localparam int HOME_W     = 3;
    localparam int TAG_W      = 8;
    localparam int NUM_SHARES = 4;
    localparam int CFG_IDX_W  = 3;

    localparam int DEF_NUM_DEVICES   = 4;
    localparam int DEF_TABLE_ENTRIES = 1024;
    localparam int DEF_HOST_TAG      = 255;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN        = 5'd6;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX        = 5'd30;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_3    = 3'd4;

    typedef struct packed {
        logic [VA_W-1:0]    vaddr;
        logic [SHARE_W-1:0] random_fraction;
    } ftpa_in_t;

    typedef struct packed {
        logic [VA_W-1:0]  physical_address;
        logic [TAG_W-1:0] home_id;
        logic             new_page;
        logic             table_full;
    } ftpa_out_t;

    typedef struct packed {
        logic [VPN_W-1:0]   vpn;
        logic [OFF_W-1:0]   offset;
        logic [SHIFT_W-1:0] shift;
        logic [HOME_W-1:0]  home;
    } ftpa_job_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } ftpa_bk_state_t;

endpackage
`default_nettype wire

FILE: sv/first_touch_page_allocator.sv
// Top level of the first-touch page allocator.
`timescale 1ns / 1ps
`default_nettype none
// Translates a virtual address to a device or host physical address, allocating a
// page on first touch. Table entries fill in order, so the fill count marks the
// valid entries and no clearing pass is needed after reset. The table sits in a
// single-port memory that is scanned one entry per cycle: a transaction waits on
// that scan, which stops at a hit or at the last entry in use. The front stage
// and a two-deep queue take further transactions while the scan runs.
// Configure only while idle; shares must be nondecreasing.
module first_touch_page_allocator
    import ftpa_pkg::*;
#(
    parameter int NUM_DEVICES   = DEF_NUM_DEVICES,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int HOST_TAG      = DEF_HOST_TAG
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SHARE_W-1:0]   cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire ftpa_in_t             item,
    output logic                      empty,
    input  wire logic                 pop,
    output ftpa_out_t                 result
);

    logic      fe_valid;
    logic      fe_ready;
    ftpa_job_t fe_job;
    logic      q_valid;
    logic      q_take;
    ftpa_job_t q_job;

    ftpa_front #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (fe_valid),
        .job       (fe_job),
        .job_ready (fe_ready)
    );

    ftpa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_data  (fe_job),
        .rd_valid (q_valid),
        .rd_take  (q_take),
        .rd_data  (q_job)
    );

    ftpa_back #(
        .NUM_DEVICES   (NUM_DEVICES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HOST_TAG      (HOST_TAG)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_take  (q_take),
        .job       (q_job),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.table_full) |-> (result.physical_address == '0 && !result.new_page))
        else $error("table full transaction carries an address");

    a_new_home: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.new_page) |->
        (result.home_id == TAG_W'(HOST_TAG) || result.home_id < TAG_W'(NUM_DEVICES)))
        else $error("allocated page has a bad home");

    a_take_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> (q_valid && empty))
        else $error("engine took a job while busy or queue empty");
`endif

endmodule
`default_nettype wire

FILE: sv/ftpa_front.sv
// Front end: configuration registers, input staging and miss home classification.
`timescale 1ns / 1ps
`default_nettype none
module ftpa_front
    import ftpa_pkg::*;
#(
    parameter int NUM_DEVICES = DEF_NUM_DEVICES
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SHARE_W-1:0]   cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire ftpa_in_t             item,
    output logic                      job_valid,
    output ftpa_job_t                 job,
    input  wire logic                 job_ready
);

    logic [SHIFT_W-1:0] page_shift_reg;
    logic [SHARE_W-1:0] share_reg [NUM_SHARES];
    logic               stage_valid_reg;
    ftpa_in_t           stage_reg;

    logic [SHIFT_W-1:0] eff_shift;
    logic [VA_W-1:0]    va_shifted;
    logic [VA_W-1:0]    off_mask;
    logic [HOME_W-1:0]  home_sel;
    logic               found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg <= PAGE_SHIFT_RESET;
            for (int i = 0; i < NUM_SHARES; i++)
            begin
                share_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PAGE_SHIFT: page_shift_reg <= cfg_data[SHIFT_W-1:0];
                REG_SHARE_0:    share_reg[0]   <= cfg_data;
                REG_SHARE_1:    share_reg[1]   <= cfg_data;
                REG_SHARE_2:    share_reg[2]   <= cfg_data;
                REG_SHARE_3:    share_reg[3]   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign full      = stage_valid_reg && !job_ready;
    assign job_valid = stage_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!full)
        begin
            stage_valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            stage_reg <= item;
        end
    end

    always_comb
    begin
        if (page_shift_reg < SHIFT_MIN)
        begin
            eff_shift = SHIFT_MIN;
        end
        else if (page_shift_reg > SHIFT_MAX)
        begin
            eff_shift = SHIFT_MAX;
        end
        else
        begin
            eff_shift = page_shift_reg;
        end
        va_shifted = stage_reg.vaddr >> eff_shift;
        off_mask   = ~({VA_W{1'b1}} << eff_shift);
        home_sel   = HOME_W'(NUM_DEVICES);
        found      = 1'b0;
        for (int i = 0; i < NUM_DEVICES; i++)
        begin
            if (!found && share_reg[i] >= stage_reg.random_fraction)
            begin
                home_sel = HOME_W'(i);
                found    = 1'b1;
            end
        end
        job.vpn    = va_shifted[VPN_W-1:0];
        job.offset = OFF_W'(stage_reg.vaddr & off_mask);
        job.shift  = eff_shift;
        job.home   = home_sel;
    end

endmodule
`default_nettype wire

FILE: sv/ftpa_queue.sv
// Two-deep job queue between the front end and the table engine.
`timescale 1ns / 1ps
`default_nettype none
module ftpa_queue
    import ftpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    input  wire ftpa_job_t wr_data,
    output logic           rd_valid,
    input  wire logic      rd_take,
    output ftpa_job_t      rd_data
);

    ftpa_job_t  slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_take && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ftpa_back.sv
// Table engine: sequential tag scan, first-touch allocation and result register.
`timescale 1ns / 1ps
`default_nettype none
module ftpa_back
    import ftpa_pkg::*;
#(
    parameter int NUM_DEVICES   = DEF_NUM_DEVICES,
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int HOST_TAG      = DEF_HOST_TAG
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      job_valid,
    output logic           job_take,
    input  wire ftpa_job_t job,
    output logic           empty,
    input  wire logic      pop,
    output ftpa_out_t      result
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [VPN_W-1:0] mem_vpn  [TABLE_ENTRIES];
    logic [TAG_W-1:0] mem_home [TABLE_ENTRIES];
    logic [CW-1:0]    mem_page [TABLE_ENTRIES];

    ftpa_bk_state_t state_reg, state_next;
    ftpa_job_t      job_reg, job_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           pend_reg, pend_next;
    logic [CW-1:0]  used_reg, used_next;
    logic [CW-1:0]  cnt_reg [NUM_DEVICES+1];
    logic [CW-1:0]  cnt_next [NUM_DEVICES+1];
    logic           out_valid_reg, out_valid_next;
    ftpa_out_t      res_reg, res_next;

    logic [VPN_W-1:0] rd_vpn_reg;
    logic [TAG_W-1:0] rd_home_reg;
    logic [CW-1:0]    rd_page_reg;
    logic             rd_en;
    logic             wr_en;
    logic [CW-1:0]    new_page_no;
    logic [TAG_W-1:0] new_tag;

    assign empty  = !out_valid_reg;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= NUM_DEVICES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i <= NUM_DEVICES; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_vpn_reg  <= mem_vpn[idx_reg[AW-1:0]];
            rd_home_reg <= mem_home[idx_reg[AW-1:0]];
            rd_page_reg <= mem_page[idx_reg[AW-1:0]];
        end
        if (wr_en)
        begin
            mem_vpn[used_reg[AW-1:0]]  <= job_reg.vpn;
            mem_home[used_reg[AW-1:0]] <= new_tag;
            mem_page[used_reg[AW-1:0]] <= new_page_no;
        end
    end

    assign new_page_no = cnt_reg[job_reg.home] + CW'(1);
    assign new_tag     = (job_reg.home < HOME_W'(NUM_DEVICES)) ?
                         TAG_W'(job_reg.home) : TAG_W'(HOST_TAG);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        used_next      = used_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        res_next       = res_reg;
        job_take       = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid && !out_valid_reg)
                begin
                    job_take   = 1'b1;
                    job_next   = job;
                    idx_next   = '0;
                    state_next = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                if (idx_reg < used_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
                if (pend_reg && rd_vpn_reg == job_reg.vpn)
                begin
                    res_next.physical_address = (VA_W'(rd_page_reg) << job_reg.shift)
                                              | VA_W'(job_reg.offset);
                    res_next.home_id    = rd_home_reg;
                    res_next.new_page   = 1'b0;
                    res_next.table_full = 1'b0;
                    out_valid_next      = 1'b1;
                    state_next          = BK_IDLE;
                end
                else if (!pend_reg && idx_reg >= used_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                    if (used_reg == CW'(TABLE_ENTRIES))
                    begin
                        res_next.physical_address = '0;
                        res_next.home_id          = '0;
                        res_next.new_page         = 1'b0;
                        res_next.table_full       = 1'b1;
                    end
                    else
                    begin
                        wr_en                     = 1'b1;
                        used_next                 = used_reg + CW'(1);
                        cnt_next[job_reg.home]    = new_page_no;
                        res_next.physical_address = (VA_W'(new_page_no) << job_reg.shift)
                                                  | VA_W'(job_reg.offset);
                        res_next.home_id          = new_tag;
                        res_next.new_page         = 1'b1;
                        res_next.table_full       = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
